@@ rtl/key_click_event_detector_macros.svh @@
// Assertion helpers for the click detector.
// KCED_ASSERT checks a property with reset masking the check.
// KCED_ASSERT_RST checks a property at every edge, reset included.
`ifndef KEY_CLICK_EVENT_DETECTOR_MACROS_SVH
`define KEY_CLICK_EVENT_DETECTOR_MACROS_SVH

`ifndef SYNTH

`define KCED_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define KCED_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define KCED_ASSERT(lbl, clk, rst, prop)

`define KCED_ASSERT_RST(lbl, clk, prop)

`endif

`endif

@@ rtl/kced_pkg.sv @@
`default_nettype none

package kced_pkg;

  localparam int unsigned TickW   = 32;
  localparam int unsigned WordW   = 16;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned ThreshW = 16;
  localparam int unsigned EventW  = 2;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  // register indexes
  localparam logic [1:0] REG_FILTER = 2'd0;
  localparam logic [1:0] REG_LONG   = 2'd1;
  localparam logic [1:0] REG_CLICK  = 2'd2;
  localparam logic [1:0] REG_LEVEL  = 2'd3;

  localparam logic [ThreshW-1:0] FILTER_RESET = 16'd50;
  localparam logic [ThreshW-1:0] LONG_RESET   = 16'd1000;
  localparam logic [ThreshW-1:0] CLICK_RESET  = 16'd300;
  localparam logic               LEVEL_RESET  = 1'b1;

  // phase codes
  localparam logic [PhaseW-1:0] PH_IDLE     = 3'd0;
  localparam logic [PhaseW-1:0] PH_PRESSED  = 3'd1;
  localparam logic [PhaseW-1:0] PH_RELEASED = 3'd2;
  localparam logic [PhaseW-1:0] PH_LONG     = 3'd3;
  localparam logic [PhaseW-1:0] PH_WAITREL  = 3'd4;

  // event codes
  localparam logic [EventW-1:0] EV_NONE   = 2'd0;
  localparam logic [EventW-1:0] EV_DOUBLE = 2'd1;
  localparam logic [EventW-1:0] EV_SINGLE = 2'd2;
  localparam logic [EventW-1:0] EV_LONG   = 2'd3;

  typedef struct packed {
    logic [ThreshW-1:0] filter_ticks;
    logic [ThreshW-1:0] long_ticks;
    logic [ThreshW-1:0] click_ticks;
    logic               press_level;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/kced_cfg_regs.sv @@
`default_nettype none

module kced_cfg_regs (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [kced_pkg::AddrW-1:0]  paddr,
  input  wire  [kced_pkg::DataW-1:0]  pwdata,
  output logic [kced_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output kced_pkg::cfg_t              cfg
);
  import kced_pkg::*;

  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_ticks <= FILTER_RESET;
      cfg.long_ticks   <= LONG_RESET;
      cfg.click_ticks  <= CLICK_RESET;
      cfg.press_level  <= LEVEL_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FILTER: cfg.filter_ticks <= pwdata[ThreshW-1:0];
        REG_LONG:   cfg.long_ticks   <= pwdata[ThreshW-1:0];
        REG_CLICK:  cfg.click_ticks  <= pwdata[ThreshW-1:0];
        REG_LEVEL:  cfg.press_level  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_FILTER: prdata[ThreshW-1:0] = cfg.filter_ticks;
      REG_LONG:   prdata[ThreshW-1:0] = cfg.long_ticks;
      REG_CLICK:  prdata[ThreshW-1:0] = cfg.click_ticks;
      REG_LEVEL:  prdata[0]           = cfg.press_level;
      default:    prdata              = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/kced_core.sv @@
`default_nettype none

module kced_core (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          step,
  input  wire  [kced_pkg::WordW-1:0]   key_word,
  input  wire  [kced_pkg::IdxW-1:0]    bit_index,
  input  wire  [kced_pkg::TickW-1:0]   now_tick,
  input  kced_pkg::cfg_t               cfg,
  output logic [kced_pkg::EventW-1:0]  ev
);
  import kced_pkg::*;

  `include "key_click_event_detector_macros.svh"

  logic [PhaseW-1:0] phase;
  logic [PhaseW-1:0] phase_next;
  logic [TickW-1:0]  time_base;
  logic [TickW-1:0]  time_base_next;

  logic             pressed;
  logic [TickW-1:0] elapsed;
  logic [TickW-1:0] filter_w;
  logic [TickW-1:0] long_w;
  logic [TickW-1:0] click_w;

  assign pressed  = (key_word[bit_index] == cfg.press_level);
  // unsigned difference stays right across tick wrap
  assign elapsed  = now_tick - time_base;
  assign filter_w = {{(TickW-ThreshW){1'b0}}, cfg.filter_ticks};
  assign long_w   = {{(TickW-ThreshW){1'b0}}, cfg.long_ticks};
  assign click_w  = {{(TickW-ThreshW){1'b0}}, cfg.click_ticks};

  always_comb begin
    phase_next     = phase;
    time_base_next = time_base;
    ev             = EV_NONE;
    unique case (phase)
      PH_IDLE: begin
        if (pressed) begin
          time_base_next = now_tick;
          phase_next     = PH_PRESSED;
        end
      end
      PH_PRESSED: begin
        if (!pressed) begin
          if (elapsed < filter_w) begin
            phase_next = PH_IDLE;
          end else begin
            time_base_next = now_tick;
            phase_next     = PH_RELEASED;
          end
        end else if (elapsed > long_w) begin
          phase_next = PH_LONG;
        end
      end
      PH_RELEASED: begin
        if (pressed && (elapsed < click_w) && (elapsed > filter_w)) begin
          phase_next = PH_WAITREL;
          ev         = EV_DOUBLE;
        end else if (elapsed >= click_w) begin
          phase_next = PH_WAITREL;
          ev         = EV_SINGLE;
        end
      end
      PH_LONG: begin
        phase_next = PH_WAITREL;
        ev         = EV_LONG;
      end
      PH_WAITREL: begin
        if (!pressed) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      time_base <= '0;
    end else if (step) begin
      phase     <= phase_next;
      time_base <= time_base_next;
    end
  end

  `KCED_ASSERT_RST(a_reset_idle, clk, rst |=> (phase == PH_IDLE && time_base == '0))
  `KCED_ASSERT(a_long_to_wait, clk, rst, (step && phase == PH_LONG) |=> phase == PH_WAITREL)
  `KCED_ASSERT(a_event_then_wait, clk, rst, (step && ev != EV_NONE) |=> phase == PH_WAITREL)
  `KCED_ASSERT(a_hold_no_step, clk, rst, !step |=> ($stable(phase) && $stable(time_base)))

endmodule

`default_nettype wire

@@ rtl/key_click_event_detector.sv @@
// Single, double and long click detector for one key of a 16-bit button word.
// Poll channel: poll_valid/poll_ready carry key_word, bit_index and now_tick;
// one request is accepted when both are high at a rising edge.
// Event channel: event_valid/event_ready carry event_res, one result for each
// request (0 none, 1 double, 2 single, 3 long click).
// Configuration: APB-style port, filter_ticks at 0x0, long_ticks at 0x4,
// click_ticks at 0x8, press_level at 0xC; pready is always high.
// Path: an accepted request waits in the input register; when it advances,
// its result moves through the phase update into the event register.
// Throughput: one request per cycle while event_ready is high, set by the
// phase update between the input register and the event register.
// Stall: while event_ready is low the event register holds its result and
// the input register still takes one more request; poll_ready then drops
// until the event is taken.
// Reset (rst, synchronous, active high): both registers empty, phase idle,
// time base zero, configuration back to 50 / 1000 / 300 / pressed-high.
`default_nettype none

module key_click_event_detector (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          poll_valid,
  output logic                         poll_ready,
  input  wire  [kced_pkg::WordW-1:0]   key_word,
  input  wire  [kced_pkg::IdxW-1:0]    bit_index,
  input  wire  [kced_pkg::TickW-1:0]   now_tick,
  output logic                         event_valid,
  input  wire                          event_ready,
  output logic [kced_pkg::EventW-1:0]  event_res,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [kced_pkg::AddrW-1:0]   paddr,
  input  wire  [kced_pkg::DataW-1:0]   pwdata,
  output logic [kced_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import kced_pkg::*;

  cfg_t cfg;

  logic               s1_valid;
  logic [WordW-1:0]   s1_word;
  logic [IdxW-1:0]    s1_idx;
  logic [TickW-1:0]   s1_now;
  logic               advance;
  logic               poll_take;
  logic [EventW-1:0]  ev;

  assign advance    = s1_valid && (!event_valid || event_ready);
  assign poll_ready = !s1_valid || advance;
  assign poll_take  = poll_valid && poll_ready;

  kced_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kced_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .key_word  (s1_word),
    .bit_index (s1_idx),
    .now_tick  (s1_now),
    .cfg       (cfg),
    .ev        (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      event_valid <= 1'b0;
    end else begin
      if (poll_take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        event_valid <= 1'b1;
      end else if (event_ready) begin
        event_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (poll_take) begin
      s1_word <= key_word;
      s1_idx  <= bit_index;
      s1_now  <= now_tick;
    end
    if (advance) begin
      event_res <= ev;
    end
  end

endmodule

`default_nettype wire

@@ test/tb_key_click_event_detector.sv @@
module tb_key_click_event_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import kced_pkg::*;

  logic               clk;
  logic               rst;
  logic               poll_valid;
  logic               poll_ready;
  logic [WordW-1:0]   key_word;
  logic [IdxW-1:0]    bit_index;
  logic [TickW-1:0]   now_tick;
  logic               event_valid;
  logic               event_ready;
  logic [EventW-1:0]  event_res;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [DataW-1:0]   pwdata;
  logic [DataW-1:0]   prdata;
  logic               pready;

  key_click_event_detector DUT (
    .clk         (clk),
    .rst         (rst),
    .poll_valid  (poll_valid),
    .poll_ready  (poll_ready),
    .key_word    (key_word),
    .bit_index   (bit_index),
    .now_tick    (now_tick),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_res   (event_res),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Mirror of the detector: configuration, phase and time base
  cfg_t               key_cfg;
  logic [PhaseW-1:0]  key_phase;
  logic [TickW-1:0]   press_base;

  logic [EventW-1:0]  events_due[$];
  logic [EventW-1:0]  due_event;
  logic [TickW-1:0]   tick_now;
  int unsigned        polls_sent;
  int unsigned        errors;
  bit                 idle_on;
  bit                 stall_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Event sink with random stall bursts
  initial begin
    event_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        event_ready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        event_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && event_valid && event_ready) begin
      if (events_due.size() == 0) begin
        errors++;
        $error("event_res: expected nothing, actual %0d", event_res);
      end else begin
        due_event = events_due.pop_front();
        if (event_res !== due_event) begin
          errors++;
          $error("event_res: expected %0d, actual %0d", due_event, event_res);
        end
      end
    end
  end

  function automatic logic [EventW-1:0] click_event(logic [WordW-1:0] word,
                                                    logic [IdxW-1:0] idx,
                                                    logic [TickW-1:0] tick);
    logic              down;
    logic [TickW-1:0]  span;
    logic [EventW-1:0] ev;
    down = (word[idx] == key_cfg.press_level);
    span = tick - press_base;
    ev   = EV_NONE;
    case (key_phase)
      PH_IDLE: begin
        if (down) begin
          press_base = tick;
          key_phase  = PH_PRESSED;
        end
      end
      PH_PRESSED: begin
        if (!down) begin
          if (span < key_cfg.filter_ticks) begin
            key_phase = PH_IDLE;
          end else begin
            press_base = tick;
            key_phase  = PH_RELEASED;
          end
        end else if (span > key_cfg.long_ticks) begin
          key_phase = PH_LONG;
        end
      end
      PH_RELEASED: begin
        if (down && span < key_cfg.click_ticks && span > key_cfg.filter_ticks) begin
          key_phase = PH_WAITREL;
          ev        = EV_DOUBLE;
        end else if (span >= key_cfg.click_ticks) begin
          key_phase = PH_WAITREL;
          ev        = EV_SINGLE;
        end
      end
      PH_LONG: begin
        key_phase = PH_WAITREL;
        ev        = EV_LONG;
      end
      PH_WAITREL: begin
        if (!down) key_phase = PH_IDLE;
      end
      default: key_phase = PH_IDLE;
    endcase
    return ev;
  endfunction

  // Called and returns at a falling edge
  task automatic send_poll(logic [WordW-1:0] word, logic [IdxW-1:0] idx,
                           logic [TickW-1:0] tick);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      poll_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    poll_valid <= 1'b1;
    key_word   <= word;
    bit_index  <= idx;
    now_tick   <= tick;
    @(posedge clk);
    while (!(poll_valid && poll_ready)) @(posedge clk);
    events_due.push_back(click_event(word, idx, tick));
    polls_sent++;
    @(negedge clk);
  endtask

  task automatic key_poll(bit down, logic [IdxW-1:0] idx, logic [TickW-1:0] tick);
    logic [WordW-1:0] word;
    word      = WordW'($urandom);
    word[idx] = down ? key_cfg.press_level : ~key_cfg.press_level;
    send_poll(word, idx, tick);
  endtask

  task automatic wait_idle();
    poll_valid <= 1'b0;
    while (events_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FILTER: key_cfg.filter_ticks = value[ThreshW-1:0];
      REG_LONG:   key_cfg.long_ticks   = value[ThreshW-1:0];
      REG_CLICK:  key_cfg.click_ticks  = value[ThreshW-1:0];
      default:    key_cfg.press_level  = value[0];
    endcase
    @(negedge clk);
  endtask

  task automatic load_config(logic [ThreshW-1:0] filt, logic [ThreshW-1:0] hold,
                             logic [ThreshW-1:0] window, logic level);
    wait_idle();
    write_reg(REG_FILTER, DataW'(filt));
    write_reg(REG_LONG, DataW'(hold));
    write_reg(REG_CLICK, DataW'(window));
    write_reg(REG_LEVEL, DataW'(level));
  endtask

  function automatic logic [ThreshW-1:0] rand_thresh(int unsigned hi);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ThreshW'($urandom_range(0, hi));
    endcase
  endfunction

  // One press, optional second press, then let the click window close.
  // Durations cluster around the current thresholds.
  task automatic click_gesture();
    logic [IdxW-1:0] idx;
    logic [TickW-1:0] t0;
    int unsigned flt, lng, win, hold, gap, steps;
    flt   = key_cfg.filter_ticks;
    lng   = key_cfg.long_ticks;
    win   = key_cfg.click_ticks;
    idx   = IdxW'($urandom_range(0, 15));
    steps = $urandom_range(1, 4);
    case ($urandom_range(0, 3))
      0:       hold = $urandom_range(0, flt + 1);
      1:       hold = $urandom_range(flt, lng + 1);
      2:       hold = lng + $urandom_range(0, 2);
      default: hold = lng + $urandom_range(1, 300);
    endcase
    case ($urandom_range(0, 3))
      0:       gap = $urandom_range(0, flt + 1);
      1:       gap = $urandom_range(flt, win);
      2:       gap = win + $urandom_range(0, 1) - ((win > 0) ? $urandom_range(0, 1) : 0);
      default: gap = $urandom_range(0, 2 * win + 2);
    endcase
    t0 = tick_now;
    key_poll(1'b1, idx, t0);
    for (int i = 1; i < steps; i++) key_poll(1'b1, idx, t0 + hold * i / steps);
    tick_now = t0 + hold;
    // hold at the end so a long hold can turn into a long click
    if ($urandom_range(0, 1)) begin
      key_poll(1'b1, idx, tick_now);
      key_poll(1'b1, idx, tick_now + 1);
      tick_now = tick_now + 1;
    end
    key_poll(1'b0, idx, tick_now);
    if ($urandom_range(0, 1)) begin
      tick_now = tick_now + gap;
      key_poll(1'b1, idx, tick_now);
      tick_now = tick_now + $urandom_range(0, flt + 5);
      key_poll(1'b0, idx, tick_now);
    end
    tick_now = tick_now + win + $urandom_range(0, 3);
    key_poll(1'b0, idx, tick_now);
    key_poll(1'b0, idx, tick_now + 1);
    tick_now = tick_now + 2;
  endtask

  task automatic gesture_or_noise();
    if ($urandom_range(0, 9) == 0) begin
      send_poll(WordW'($urandom), IdxW'($urandom), $urandom);
    end else begin
      click_gesture();
    end
  endtask

  task automatic test_directed_gestures();
    idle_on  = 1'b1;
    stall_on = 1'b1;
    send_poll(16'h0000, 4'd0, 32'd0);
    // press shorter than the filter is dropped
    send_poll(16'hFFFF, 4'd15, 32'd10);
    send_poll(16'h0000, 4'd15, 32'd20);
    // press, release, second press inside the window
    send_poll(16'h0001, 4'd0, 32'd100);
    key_poll(1'b0, 4'd0, 32'd150);
    key_poll(1'b1, 4'd0, 32'd200);
    key_poll(1'b1, 4'd0, 32'd449);
    key_poll(1'b1, 4'd0, 32'd500);
    key_poll(1'b0, 4'd0, 32'd510);
    // long hold
    key_poll(1'b1, 4'd7, 32'd1000);
    key_poll(1'b1, 4'd7, 32'd2000);
    key_poll(1'b1, 4'd7, 32'd2001);
    key_poll(1'b1, 4'd7, 32'd2002);
    key_poll(1'b0, 4'd7, 32'd2003);
    // window runs out
    key_poll(1'b1, 4'd3, 32'd3000);
    key_poll(1'b0, 4'd3, 32'd3100);
    key_poll(1'b0, 4'd3, 32'd3399);
    key_poll(1'b0, 4'd3, 32'd3400);
    key_poll(1'b0, 4'd3, 32'd3401);
    // tick count wraps during the press
    key_poll(1'b1, 4'd12, 32'hFFFF_FFF0);
    key_poll(1'b0, 4'd12, 32'h0000_0040);
    key_poll(1'b1, 4'd12, 32'h0000_0040 + 32'd300);
    key_poll(1'b0, 4'd12, 32'hFFFF_FFFF);
  endtask

  task automatic test_threshold_extremes();
    logic [TickW-1:0] t;
    load_config('0, '0, '0, 1'b0);
    t = $urandom;
    key_poll(1'b1, 4'd5, t);
    key_poll(1'b1, 4'd5, t);
    key_poll(1'b1, 4'd5, t + 1);
    key_poll(1'b1, 4'd5, t + 1);
    key_poll(1'b0, 4'd5, t + 2);
    key_poll(1'b1, 4'd5, t + 3);
    key_poll(1'b0, 4'd5, t + 3);
    key_poll(1'b0, 4'd5, t + 3);
    key_poll(1'b0, 4'd5, t + 4);
    tick_now = t + 5;
    repeat (15) gesture_or_noise();
    load_config('1, '1, '1, 1'b1);
    tick_now = $urandom;
    repeat (12) gesture_or_noise();
  endtask

  task automatic test_random_gestures();
    int unsigned stop_at;
    for (int ph = 0; ph < 6; ph++) begin
      load_config(rand_thresh(300), rand_thresh(1500), rand_thresh(600), 1'($urandom));
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      tick_now = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4000)
                                             : 32'($urandom);
      stop_at  = polls_sent + 80;
      while (polls_sent < stop_at) gesture_or_noise();
    end
  endtask

  task automatic test_quiet_tail();
    int unsigned stop_at;
    load_config(16'd50, 16'd1000, 16'd300, 1'b1);
    idle_on  = 1'b0;
    stall_on = 1'b0;
    stop_at  = polls_sent + 100;
    while (polls_sent < stop_at) gesture_or_noise();
  endtask

  initial begin
    rst        = 1'b1;
    poll_valid = 1'b0;
    key_word   = '0;
    bit_index  = '0;
    now_tick   = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    idle_on    = 1'b0;
    stall_on   = 1'b0;
    errors     = 0;
    polls_sent = 0;
    tick_now   = '0;
    key_cfg    = '{filter_ticks: FILTER_RESET, long_ticks: LONG_RESET,
                   click_ticks: CLICK_RESET, press_level: LEVEL_RESET};
    key_phase  = PH_IDLE;
    press_base = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_gestures();
    test_threshold_extremes();
    test_random_gestures();
    test_quiet_tail();

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/kced_pkg.sv
rtl/kced_cfg_regs.sv
rtl/kced_core.sv
rtl/key_click_event_detector.sv
test/tb_key_click_event_detector.sv
